// File: src/iovj_pkg.sv
// ============================================================================
// Interval overlap join package
// Shared sizes, codes and the stored entry type.
// ============================================================================
`default_nettype none

package iovj_pkg;

    localparam int ENTRIES       = 64;
    localparam int IDX_W         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W         = $clog2(ENTRIES + 1);
    localparam int RESULT_CAP    = 64;
    localparam int NRES_W        = $clog2(RESULT_CAP);
    localparam int CHROM_W       = 16;
    localparam int COORD_W       = 31;
    localparam int ACTION_W      = 2;
    localparam int STATUS_W      = 3;
    localparam int ENTRY_INDEX_W = 6;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] STS_MATCH   = 3'd0;
    localparam logic [STATUS_W-1:0] STS_NOMATCH = 3'd1;
    localparam logic [STATUS_W-1:0] STS_LOADED  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] STS_CLEARED = 3'd4;

    localparam logic [0:0] REG_FIRST_ONLY = 1'd0;

    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [COORD_W-1:0] rng_start;
        logic [COORD_W-1:0] rng_end;
    } entry_t;

endpackage

`default_nettype wire

// File: src/iovj_table.sv
// ============================================================================
// Interval table
// Single-port-write, single-port-read interval memory with a registered read
// and the half-open overlap test against the current query.
// ============================================================================
`default_nettype none

module iovj_table (
    input  wire                          aclk,
    input  wire                          wr_en,
    input  wire [iovj_pkg::IDX_W-1:0]    wr_addr,
    input  iovj_pkg::entry_t             wr_data,
    input  wire                          rd_en,
    input  wire [iovj_pkg::IDX_W-1:0]    rd_addr,
    input  iovj_pkg::entry_t             qry,
    output logic                         hit
);

    iovj_pkg::entry_t table_mem [iovj_pkg::ENTRIES];
    iovj_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    // The smaller end exceeds the larger start exactly when each end exceeds
    // each start.
    always_comb begin
        hit = (rd_data_reg.chrom == qry.chrom)
            && (qry.rng_end > rd_data_reg.rng_start)
            && (rd_data_reg.rng_end > qry.rng_start)
            && (qry.rng_end > qry.rng_start)
            && (rd_data_reg.rng_end > rd_data_reg.rng_start);
    end

endmodule

`default_nettype wire

// File: src/interval_overlap_join.sv
// ============================================================================
// Interval overlap join
// Table of reference intervals with clear, load and overlap query words.
// ============================================================================
// A clear or load word moves to the RESP state, which registers one result word
// once the output side is free and then returns to idle for the next input
// word. A query walks the stored entries in index order, one table read a
// cycle through the single read port of the interval memory while no held-back
// match stalls it, and stops early after the first match in first-only mode or
// when the result cap is reached. Only one input word is in work at a time.
`default_nettype none

module interval_overlap_join (
    input  wire                                   aclk,
    input  wire                                   aresetn,

    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire [iovj_pkg::ACTION_W-1:0]          s_action,
    input  wire [iovj_pkg::CHROM_W-1:0]           s_chrom_id,
    input  wire [iovj_pkg::COORD_W-1:0]           s_range_start,
    input  wire [iovj_pkg::COORD_W-1:0]           s_range_end,

    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic [iovj_pkg::STATUS_W-1:0]         m_status,
    output logic [iovj_pkg::ENTRY_INDEX_W-1:0]    m_entry_index,
    output logic                                  m_last,

    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire [iovj_pkg::PADDR_W-1:0]           paddr,
    input  wire [iovj_pkg::PDATA_W-1:0]           pwdata,
    output logic [iovj_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0]                         state_reg, state_next;
    logic                               first_only_reg, first_only_next;
    logic [iovj_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [iovj_pkg::CNT_W-1:0]         scan_idx_reg, scan_idx_next;
    logic [iovj_pkg::IDX_W-1:0]         rd_idx_reg, rd_idx_next;
    logic                               cmp_valid_reg, cmp_valid_next;
    logic                               pend_valid_reg, pend_valid_next;
    logic [iovj_pkg::IDX_W-1:0]         pend_idx_reg, pend_idx_next;
    logic [iovj_pkg::NRES_W-1:0]        nres_reg, nres_next;
    iovj_pkg::entry_t                   qry_reg, qry_next;
    logic [iovj_pkg::STATUS_W-1:0]      resp_status_reg, resp_status_next;
    logic [iovj_pkg::IDX_W-1:0]         resp_idx_reg, resp_idx_next;

    logic                               m_valid_reg, m_valid_next;
    logic [iovj_pkg::STATUS_W-1:0]      m_status_reg, m_status_next;
    logic [iovj_pkg::ENTRY_INDEX_W-1:0] m_index_reg, m_index_next;
    logic                               m_last_reg, m_last_next;

    iovj_pkg::entry_t                   in_entry;
    logic                               in_accept;
    logic                               out_free;
    logic                               cfg_write;
    logic                               tbl_hit;
    logic                               cmp_hit;
    logic                               stall;
    logic                               final_hit;
    logic                               issue;
    logic                               scan_done;
    logic                               wr_en;

    assign s_ready       = (state_reg == ST_IDLE);
    assign in_accept     = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_index = m_index_reg;
    assign m_last        = m_last_reg;
    assign out_free      = !m_valid_reg || m_ready;
    assign pready        = 1'b1;
    assign cfg_write     = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (paddr[2] == iovj_pkg::REG_FIRST_ONLY) begin
            prdata[0] = first_only_reg;
        end
    end

    always_comb begin
        in_entry.chrom = s_chrom_id;
        if (s_range_start > s_range_end) begin
            in_entry.rng_start = s_range_end;
            in_entry.rng_end   = s_range_start;
        end else begin
            in_entry.rng_start = s_range_start;
            in_entry.rng_end   = s_range_end;
        end
    end

    assign wr_en = in_accept && (s_action == iovj_pkg::ACT_LOAD)
                   && (count_reg < iovj_pkg::CNT_W'(iovj_pkg::ENTRIES));

    assign cmp_hit   = (state_reg == ST_SCAN) && cmp_valid_reg && tbl_hit;
    assign stall     = cmp_hit && pend_valid_reg && !out_free;
    assign final_hit = cmp_hit && !stall
                       && (first_only_reg
                           || (nres_reg == iovj_pkg::NRES_W'(iovj_pkg::RESULT_CAP - 1)));
    assign issue     = (state_reg == ST_SCAN) && (scan_idx_reg < count_reg)
                       && !stall && !final_hit;
    assign scan_done = (state_reg == ST_SCAN) && !cmp_valid_reg
                       && (scan_idx_reg >= count_reg);

    iovj_table u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[iovj_pkg::IDX_W-1:0]),
        .wr_data (in_entry),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg[iovj_pkg::IDX_W-1:0]),
        .qry     (qry_reg),
        .hit     (tbl_hit)
    );

    always_comb begin
        state_next       = state_reg;
        first_only_next  = first_only_reg;
        count_next       = count_reg;
        scan_idx_next    = scan_idx_reg;
        rd_idx_next      = rd_idx_reg;
        cmp_valid_next   = cmp_valid_reg;
        pend_valid_next  = pend_valid_reg;
        pend_idx_next    = pend_idx_reg;
        nres_next        = nres_reg;
        qry_next         = qry_reg;
        resp_status_next = resp_status_reg;
        resp_idx_next    = resp_idx_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_index_next     = m_index_reg;
        m_last_next      = m_last_reg;

        if (cfg_write && (paddr[2] == iovj_pkg::REG_FIRST_ONLY)) begin
            first_only_next = pwdata[0];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    unique case (s_action)
                        iovj_pkg::ACT_CLEAR: begin
                            count_next       = '0;
                            resp_status_next = iovj_pkg::STS_CLEARED;
                            resp_idx_next    = '0;
                            state_next       = ST_RESP;
                        end
                        iovj_pkg::ACT_LOAD: begin
                            if (wr_en) begin
                                resp_status_next = iovj_pkg::STS_LOADED;
                                resp_idx_next    = count_reg[iovj_pkg::IDX_W-1:0];
                                count_next       = count_reg + 1'b1;
                            end else begin
                                resp_status_next = iovj_pkg::STS_FULL;
                                resp_idx_next    = '0;
                            end
                            state_next = ST_RESP;
                        end
                        iovj_pkg::ACT_QUERY: begin
                            qry_next        = in_entry;
                            scan_idx_next   = '0;
                            nres_next       = '0;
                            pend_valid_next = 1'b0;
                            cmp_valid_next  = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    rd_idx_next   = scan_idx_reg[iovj_pkg::IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                cmp_valid_next = stall || issue;
                if (cmp_hit && !stall) begin
                    if (pend_valid_reg) begin
                        m_valid_next  = 1'b1;
                        m_status_next = iovj_pkg::STS_MATCH;
                        m_index_next  = iovj_pkg::ENTRY_INDEX_W'(pend_idx_reg);
                        m_last_next   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_idx_next   = rd_idx_reg;
                    nres_next       = nres_reg + 1'b1;
                end
                if (final_hit || scan_done) begin
                    cmp_valid_next = 1'b0;
                    state_next     = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    if (pend_valid_reg) begin
                        m_status_next = iovj_pkg::STS_MATCH;
                        m_index_next  = iovj_pkg::ENTRY_INDEX_W'(pend_idx_reg);
                    end else begin
                        m_status_next = iovj_pkg::STS_NOMATCH;
                        m_index_next  = '0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = resp_status_reg;
                    m_index_next  = iovj_pkg::ENTRY_INDEX_W'(resp_idx_reg);
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            first_only_reg <= 1'b0;
            count_reg      <= '0;
            cmp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            nres_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            first_only_reg <= first_only_next;
            count_reg      <= count_next;
            cmp_valid_reg  <= cmp_valid_next;
            pend_valid_reg <= pend_valid_next;
            nres_reg       <= nres_next;
            m_valid_reg    <= m_valid_next;
        end
        scan_idx_reg    <= scan_idx_next;
        rd_idx_reg      <= rd_idx_next;
        pend_idx_reg    <= pend_idx_next;
        qry_reg         <= qry_next;
        resp_status_reg <= resp_status_next;
        resp_idx_reg    <= resp_idx_next;
        m_status_reg    <= m_status_next;
        m_index_reg     <= m_index_next;
        m_last_reg      <= m_last_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= iovj_pkg::CNT_W'(iovj_pkg::ENTRIES))
        else $error("Entry count exceeds the table depth.");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && cmp_valid_reg)
        |-> (iovj_pkg::CNT_W'(rd_idx_reg) < count_reg))
        else $error("Compared entry lies beyond the loaded entries.");

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg && !cmp_valid_reg)
        else $error("Scan state left behind while idle.");

    a_final_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        final_hit |=> (state_reg == ST_FLUSH) && pend_valid_reg)
        else $error("Final match did not end the scan.");

endmodule

`default_nettype wire
